// ===== design/ppi_pkg.sv =====
// ----------------------------------------------------------------------------
// ppi_pkg: shared types and constants of the planar pose integrator
// Fixed-point formats, command and status codes, sequencer states and the
// CORDIC arctangent table in units of 2^-16 degree.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int POS_WIDTH    = 32;

    // field widths
    localparam int OP_W      = 3;
    localparam int AMT_W     = 24;
    localparam int HEAD_W    = 17;
    localparam int STAT_W    = 2;
    localparam int OUT_POS_W = 32;

    // stream payload widths
    localparam int S_TDATA_W   = ((AMT_W + 7) / 8) * 8;
    localparam int M_PAYLOAD_W = 2 * OUT_POS_W + HEAD_W;
    localparam int M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_PAYLOAD_W;

    // datapath widths
    localparam int XY_W       = 32;              // Q30 cos/sin with headroom
    localparam int Z_W        = 27;              // angle, 2^-16 degree
    localparam int FRAC       = 30;
    localparam int PROD_W     = AMT_W + XY_W;
    localparam int DELTA_W    = PROD_W - FRAC;
    localparam int SUM_W      = ((POS_WIDTH > DELTA_W) ? POS_WIDTH : DELTA_W) + 1;
    localparam int STEP_W     = $clog2(CORDIC_STEPS);
    localparam int TABLE_LEN  = 24;
    localparam int ATAN_IDX_W = $clog2(TABLE_LEN);
    localparam int REM_W      = AMT_W - 1;       // magnitude of a positive amount
    localparam int MOD_STEPS  = 7;               // 92160 * 2^7 exceeds any amount
    localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

    // heading constants, 1/256 degree
    localparam logic [HEAD_W-1:0] HEADING_MOD = 17'd92160;
    localparam logic [HEAD_W-1:0] HEAD_90     = 17'd23040;
    localparam logic [HEAD_W-1:0] HEAD_270    = 17'd69120;
    localparam logic [HEAD_W-1:0] HEAD_180    = 17'd46080;

    localparam logic signed [XY_W-1:0]   CORDIC_GAIN = 32'sd652032875;
    localparam logic signed [PROD_W-1:0] ROUND_HALF  = PROD_W'(64'd1 << (FRAC - 1));

    localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    // command codes
    localparam logic [OP_W-1:0] OP_FWD    = 3'd0;
    localparam logic [OP_W-1:0] OP_LEFT   = 3'd1;
    localparam logic [OP_W-1:0] OP_RIGHT  = 3'd2;
    localparam logic [OP_W-1:0] OP_STATUS = 3'd3;
    localparam logic [OP_W-1:0] OP_BACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_RESET  = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_MULX,
        S_MULY,
        S_ACCY,
        S_MOD,
        S_TURN,
        S_OUT
    } state_t;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 27'sd2949120;
            5'd1:    v = 27'sd1740967;
            5'd2:    v = 27'sd919879;
            5'd3:    v = 27'sd466945;
            5'd4:    v = 27'sd234379;
            5'd5:    v = 27'sd117304;
            5'd6:    v = 27'sd58666;
            5'd7:    v = 27'sd29335;
            5'd8:    v = 27'sd14668;
            5'd9:    v = 27'sd7334;
            5'd10:   v = 27'sd3667;
            5'd11:   v = 27'sd1833;
            5'd12:   v = 27'sd917;
            5'd13:   v = 27'sd458;
            5'd14:   v = 27'sd229;
            5'd15:   v = 27'sd115;
            5'd16:   v = 27'sd57;
            5'd17:   v = 27'sd29;
            5'd18:   v = 27'sd14;
            5'd19:   v = 27'sd7;
            5'd20:   v = 27'sd4;
            5'd21:   v = 27'sd2;
            5'd22:   v = 27'sd1;
            default: v = 27'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/planar_pose_integrator.sv =====
// ----------------------------------------------------------------------------
// planar_pose_integrator: dead-reckoning update of a planar x/y/heading pose
// Move, turn, status and reset requests; one result request per command.
// ----------------------------------------------------------------------------
// Move: 16 CORDIC steps, two multiplies on the shared 24x32 multiplier and two
//   saturating adds before the result; turn: 7 compare/subtract steps of the
//   modulo unit; other commands go straight to the output state.
// The input is ready only in the idle state, so the next request can be
//   accepted only once the result is raised, while that result is valid.
// The result register lets the next command start while a result waits.
// Reset (rst_n low, asynchronous) zeroes the pose and empties the output.
// ----------------------------------------------------------------------------
module planar_pose_integrator
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // command stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ppi_pkg::S_TDATA_W-1:0]         s_axis_tdata,  // [23:0] amount
    input  logic [ppi_pkg::OP_W-1:0]              s_axis_tuser,  // [2:0] opcode
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [ppi_pkg::M_TDATA_W-1:0]         m_axis_tdata,  // [31:0] pos_x,
                                                                 // [63:32] pos_y,
                                                                 // [80:64] heading
    output logic [ppi_pkg::STAT_W-1:0]            m_axis_tuser   // [1:0] status
);
    import ppi_pkg::*;

    state_t state_reg, state_next;

    logic signed [POS_WIDTH-1:0] x_acc_reg, x_acc_next;
    logic signed [POS_WIDTH-1:0] y_acc_reg, y_acc_next;
    logic [HEAD_W-1:0]           heading_reg, heading_next;
    logic [STAT_W-1:0]           status_reg, status_next;
    logic                        back_reg, back_next;   // backward move
    logic                        left_reg, left_next;   // left turn
    logic signed [AMT_W-1:0]     amt_reg, amt_next;
    logic [REM_W-1:0]            rem_reg, rem_next;
    logic [MOD_CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;

    logic                        m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]        m_data_reg, m_data_next;
    logic [STAT_W-1:0]           m_user_reg, m_user_next;

    logic                        in_fire;
    logic signed [AMT_W-1:0]     in_amt;
    logic                        amt_bad;
    logic                        cordic_start;
    logic                        cordic_done;
    logic signed [XY_W-1:0]      cos_q, sin_q;

    logic signed [XY_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]    mul_p;

    logic [REM_W:0]              mod_div;
    logic [HEAD_W:0]             turn_sum;
    logic [HEAD_W:0]             turn_wrap;
    logic signed [PROD_W-1:0]    prod_rnd;
    logic signed [DELTA_W-1:0]   delta;
    logic signed [SUM_W-1:0]     acc_sum;
    logic signed [POS_WIDTH-1:0] acc_base;
    logic signed [POS_WIDTH-1:0] acc_new;
    logic                        acc_sat;
    logic signed [63:0]          x_ext, y_ext;

    assign in_amt        = signed'(s_axis_tdata[AMT_W-1:0]);
    assign amt_bad       = in_amt[AMT_W-1] || (in_amt == '0);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cordic_start  = in_fire && !amt_bad &&
                           (s_axis_tuser == OP_FWD || s_axis_tuser == OP_BACK);

    ppi_cordic u_cordic
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .head  (heading_reg),
        .done  (cordic_done),
        .cos_q (cos_q),
        .sin_q (sin_q)
    );

    // one 24x32 multiplier: cos in the x step, sin in the y step
    assign mul_b = (state_reg == S_MULY) ? sin_q : cos_q;
    assign mul_p = amt_reg * mul_b;

    // modulo step divisor: 92160 scaled by 2^cnt
    assign mod_div = (REM_W + 1)'(HEADING_MOD) << cnt_reg;

    // heading after the reduced turn, wrapped back into [0, 360)
    always_comb
    begin
        if (left_reg)
        begin
            turn_sum  = {1'b0, heading_reg} + (HEAD_W + 1)'(rem_reg);
            turn_wrap = (turn_sum >= (HEAD_W + 1)'(HEADING_MOD)) ?
                        turn_sum - (HEAD_W + 1)'(HEADING_MOD) : turn_sum;
        end
        else
        begin
            turn_sum  = {1'b0, heading_reg} - (HEAD_W + 1)'(rem_reg);
            turn_wrap = (heading_reg >= HEAD_W'(rem_reg)) ?
                        turn_sum : turn_sum + (HEAD_W + 1)'(HEADING_MOD);
        end
    end

    // round Q38 product to Q8, then saturating accumulate
    always_comb
    begin
        prod_rnd = prod_reg + ROUND_HALF;
        delta    = prod_rnd[PROD_W-1:FRAC];
        if (back_reg)
            delta = -delta;
        acc_base = (state_reg == S_MULY) ? x_acc_reg : y_acc_reg;
        acc_sum  = SUM_W'(acc_base) + SUM_W'(delta);
        acc_sat  = 1'b0;
        acc_new  = acc_sum[POS_WIDTH-1:0];
        if (acc_sum > SUM_W'(POS_MAX))
        begin
            acc_new = POS_MAX;
            acc_sat = 1'b1;
        end
        else if (acc_sum < SUM_W'(POS_MIN))
        begin
            acc_new = POS_MIN;
            acc_sat = 1'b1;
        end
    end

    assign x_ext = 64'(x_acc_reg);
    assign y_ext = 64'(y_acc_reg);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        x_acc_next   = x_acc_reg;
        y_acc_next   = y_acc_reg;
        heading_next = heading_reg;
        status_next  = status_reg;
        back_next    = back_reg;
        left_next    = left_reg;
        amt_next     = amt_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (m_valid_reg && m_axis_tready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    amt_next    = in_amt;
                    rem_next    = in_amt[REM_W-1:0];
                    back_next   = (s_axis_tuser == OP_BACK);
                    left_next   = (s_axis_tuser == OP_LEFT);
                    cnt_next    = MOD_CNT_W'(MOD_STEPS - 1);
                    status_next = ST_DONE;
                    state_next  = S_OUT;
                    case (s_axis_tuser)
                        OP_FWD, OP_BACK:
                        begin
                            if (amt_bad)
                                status_next = ST_REJECT;
                            else
                                state_next = S_ROT;
                        end
                        OP_LEFT, OP_RIGHT:
                        begin
                            if (amt_bad)
                                status_next = ST_REJECT;
                            else
                                state_next = S_MOD;
                        end
                        OP_RESET:
                        begin
                            x_acc_next   = '0;
                            y_acc_next   = '0;
                            heading_next = '0;
                        end
                        default:
                        begin
                            // status and unused codes report the pose only
                        end
                    endcase
                end
            end
            S_ROT:
            begin
                if (cordic_done)
                    state_next = S_MULX;
            end
            S_MULX:
            begin
                prod_next  = mul_p;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                x_acc_next = acc_new;
                if (acc_sat)
                    status_next = ST_SAT;
                prod_next  = mul_p;
                state_next = S_ACCY;
            end
            S_ACCY:
            begin
                y_acc_next = acc_new;
                if (acc_sat)
                    status_next = ST_SAT;
                state_next = S_OUT;
            end
            S_MOD:
            begin
                if ({1'b0, rem_reg} >= mod_div)
                    rem_next = rem_reg - mod_div[REM_W-1:0];
                if (cnt_reg == '0)
                    state_next = S_TURN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_TURN:
            begin
                heading_next = turn_wrap[HEAD_W-1:0];
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{M_PAD_W{1'b0}}, heading_reg,
                                    y_ext[OUT_POS_W-1:0], x_ext[OUT_POS_W-1:0]};
                    m_user_next  = status_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            x_acc_reg   <= '0;
            y_acc_reg   <= '0;
            heading_reg <= '0;
            status_reg  <= ST_DONE;
            back_reg    <= 1'b0;
            left_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            x_acc_reg   <= x_acc_next;
            y_acc_reg   <= y_acc_next;
            heading_reg <= heading_next;
            status_reg  <= status_next;
            back_reg    <= back_next;
            left_reg    <= left_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg    <= amt_next;
        rem_reg    <= rem_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2*OUT_POS_W +: HEAD_W] < HEADING_MOD))
        else $error("reported heading outside one turn");

    a_cordic_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == S_ROT))
        else $error("cordic finished outside the rotation wait");

    a_reject_keeps_pose: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && amt_bad && (s_axis_tuser == OP_FWD || s_axis_tuser == OP_BACK ||
         s_axis_tuser == OP_LEFT || s_axis_tuser == OP_RIGHT))
        |=> ($stable(x_acc_reg) && $stable(y_acc_reg) && $stable(heading_reg)))
        else $error("rejected command changed the pose");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output state");

endmodule

// ===== design/ppi_cordic.sv =====
// ----------------------------------------------------------------------------
// ppi_cordic: iterative rotation-mode CORDIC in degrees
// One micro-rotation per cycle; returns cos and sin of the heading in Q30.
// ----------------------------------------------------------------------------
module ppi_cordic
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [ppi_pkg::HEAD_W-1:0]            head,
    output logic                                  done,
    output logic signed [ppi_pkg::XY_W-1:0]       cos_q,
    output logic signed [ppi_pkg::XY_W-1:0]       sin_q
);
    import ppi_pkg::*;

    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic                   flip_reg;

    logic signed [HEAD_W:0] head_fold;
    logic                   fold_flip;
    logic signed [XY_W-1:0] x_sh, y_sh;
    logic signed [Z_W-1:0]  atan_v;
    logic                   last_step;

    // fold into [-90, 90] degrees
    always_comb
    begin
        fold_flip = 1'b0;
        head_fold = signed'({1'b0, head});
        if (head > HEAD_90 && head < HEAD_270)
        begin
            head_fold = signed'({1'b0, head}) - signed'({1'b0, HEAD_180});
            fold_flip = 1'b1;
        end
        else if (head >= HEAD_270)
        begin
            head_fold = signed'({1'b0, head}) - signed'({1'b0, HEADING_MOD});
        end
    end

    assign x_sh      = x_reg >>> step_reg;
    assign y_sh      = y_reg >>> step_reg;
    assign atan_v    = atan_deg(ATAN_IDX_W'(step_reg));
    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (last_step)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= Z_W'(head_fold) <<< 8;
            flip_reg <= fold_flip;
        end
        else if (busy_reg)
        begin
            // zero residual rotates as positive
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_v;
            end
        end
    end

    assign done  = done_reg;
    assign cos_q = flip_reg ? -x_reg : x_reg;
    assign sin_q = flip_reg ? -y_reg : y_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg))
        else $error("cordic done without a running rotation");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("cordic restarted while busy");

    a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last_step && !start) |=> (!busy_reg && done))
        else $error("cordic did not finish after last step");

endmodule
